>>> rtl/lu_factor_and_solve_macros.svh
// assertion macros for the lu factor and solve block
// used by files that check their own control logic; no other dependencies
`ifndef LU_FACTOR_AND_SOLVE_MACROS_SVH
`define LU_FACTOR_AND_SOLVE_MACROS_SVH
`ifndef SYNTHESIS
`define LUFS_ASSERT_IMP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LUFS_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define LUFS_ASSERT_IMP(label, clk, rst_n, prop, msg)
`define LUFS_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

>>> rtl/lufs_pkg.sv
// shared types and codes of the lu factor and solve block
// no dependencies
package lufs_pkg;

	localparam logic OP_MATRIX = 1'b0;
	localparam logic OP_RHS = 1'b1;

	localparam logic KIND_FACTOR = 1'b0;
	localparam logic KIND_SOLVE = 1'b1;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_TOL = 2'd1;

	typedef enum logic [2:0] {
		STAT_OK = 3'd0,
		STAT_SINGULAR = 3'd1,
		STAT_SMALL_DIAG = 3'd2,
		STAT_BAD_CFG = 3'd3,
		STAT_UNFACTORED = 3'd4
	} status_t;

	typedef struct packed {
		logic operation;
		logic signed [31:0] value;
	} item_t;

	typedef struct packed {
		logic kind;
		status_t status;
		logic [2:0] element_index;
		logic signed [31:0] solution_value;
		logic last;
	} result_t;

	typedef enum logic [5:0] {
		S_IDLE, S_STAT,
		S_PV_RD, S_PV_CMP, S_PV_DONE,
		S_SW_RA, S_SW_RB, S_SW_WA, S_SW_WB,
		S_PERM_A, S_PERM_B, S_PERM_C,
		S_NEXTI, S_NEXTK,
		S_EL_RD, S_EL_DIV, S_EL_DWAIT,
		S_EU_RA, S_EU_RB, S_EU_WR,
		S_FW_START, S_FW_RD, S_FW_MUL, S_FW_ACC, S_FW_WR,
		S_BK_RD, S_BK_CHK, S_BK_RA, S_BK_MUL, S_BK_ACC, S_BK_DIV, S_BK_DWAIT,
		S_EMIT
	} seq_state_t;

endpackage

>>> rtl/lufs_ram.sv
// matrix storage: one write port, one read port, registered read data
// no dependencies
module lufs_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32,
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/lufs_div.sv
// iterative fixed point divider, one quotient bit per cycle, saturating
// depends on nothing but its parameters
module lufs_div #(
	parameter int NW = 37,
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] num,
	input  logic signed [31:0]   den,
	output logic                 done,
	output logic signed [31:0]   quot
);

	localparam int DW = NW + FRAC_BITS;
	localparam int CNTW = $clog2(DW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [DW-1:0]   dvd_q;
	logic [DW-1:0]   quo_q;
	logic [32:0]     rem_q;
	logic [32:0]     dmag_q;
	logic            neg_q;
	logic            zero_q;
	logic            numneg_q;

	logic [NW-1:0] nmag;
	logic signed [32:0] den_w;
	logic [33:0] trial;
	logic [33:0] diff;
	logic [DW-1:0] negq;

	always_comb begin
		nmag = num[NW-1] ? NW'(-num) : NW'(num);
		den_w = 33'(den);
		trial = {rem_q, dvd_q[DW-1]};
		diff = trial - {1'b0, dmag_q};
		negq = -quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNTW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNTW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {nmag, {FRAC_BITS{1'b0}}};
			quo_q <= '0;
			rem_q <= '0;
			dmag_q <= den_w[32] ? 33'(-den_w) : 33'(den_w);
			neg_q <= num[NW-1] ^ den[31];
			zero_q <= (den == 32'sd0);
			numneg_q <= num[NW-1];
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			if (!diff[33]) begin
				rem_q <= diff[32:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= trial[32:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (zero_q) begin
			quot = numneg_q ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else if (neg_q) begin
			quot = (quo_q > DW'(64'h8000_0000)) ? 32'sh8000_0000 : $signed(negq[31:0]);
		end else begin
			quot = (quo_q > DW'(64'h7fff_ffff)) ? 32'sh7fff_ffff : $signed(quo_q[31:0]);
		end
	end

	assign done = done_q;

endmodule

>>> rtl/lu_factor_and_solve.sv
// lu factorization with partial pivoting and triangular solve, top level
// depends on lufs_pkg, lufs_ram, lufs_div and lu_factor_and_solve_macros.svh
//
// channel   direction  handshake                    payload
// item      in         item_valid / item_ready      item_t (operation, value)
// result    out        result_valid / result_ready  result_t
// cfg       in         cfg_valid / cfg_ready        cfg_index, cfg_data
//
// a matrix or rhs element that starts no work leaves the block idle for the next item
// the last matrix element starts factoring: per column a pivot search over the rows, a
// row swap when the pivot lies below, a divider pass per row below the pivot and an
// update of each remaining element of that row
// the last rhs element starts the solve: forward products, back products with one divider
// pass per row, then one result per cycle while result_ready stays high
// no clearing pass after reset; a stalled result holds while new items are still taken
`include "lu_factor_and_solve_macros.svh"
module lu_factor_and_solve import lufs_pkg::*; #(
	parameter int MAX_N = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  item_t                item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int IW = $clog2(MAX_N);
	localparam int CW = $clog2(MAX_N + 1);
	localparam int AW = 33 + IW;
	localparam int NW = AW + 1;
	localparam int AD = $clog2(MAX_N * MAX_N);

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sh7fff_ffff) begin
			sat32 = 32'sh7fff_ffff;
		end else if (v < -64'sh8000_0000) begin
			sat32 = 32'sh8000_0000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

	function automatic logic [32:0] mag33(input logic signed [31:0] v);
		logic signed [32:0] w;
		w = 33'(v);
		mag33 = w[32] ? 33'(-w) : 33'(w);
	endfunction

	function automatic logic [AD-1:0] addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
		addr = AD'(32'(r) * MAX_N + 32'(c));
	endfunction

	seq_state_t state_q, state_d;

	logic [3:0]  n_cfg_q;
	logic [30:0] tol_q;
	logic        fok_q;
	logic [CW-1:0] ld_r_q, ld_c_q, rcnt_q;
	logic [CW-1:0] k_q, i_q, j_q, best_q, e_q;
	logic [32:0] bm_q;
	logic signed [31:0] piv_q, m_q, a_q;
	logic [IW-1:0] tmp_q;
	logic signed [AW-1:0] acc_q;
	logic signed [63:0] prod_s1;
	logic stat_kind_q;
	status_t stat_code_q;
	logic [IW-1:0] perm_q [MAX_N];
	logic signed [31:0] rhs_q [MAX_N];
	logic signed [31:0] work_q [MAX_N];
	logic    result_valid_q;
	result_t result_q;

	logic [CW-1:0] n_w;
	logic cfg_bad, item_fire, cfg_fire, out_free, out_load;
	logic [CW-1:0] i_inc, j_inc, k_inc, e_inc;
	logic i_last, j_last, k_last, e_last, ld_r_last, ld_c_last, rcnt_last;
	logic [32:0] tol33;
	logic signed [31:0] rdata, fxp, elim_val, work_rd, mul_a, fw_val;
	logic [31:0] ram_rdata, ram_wdata;
	logic [AD-1:0] ram_raddr, ram_waddr;
	logic ram_we;
	logic [CW-1:0] rd_r, rd_c, wr_r, wr_c;
	logic [CW-1:0] perm_ra, work_ra;
	logic [IW-1:0] perm_rd;
	logic div_start, div_done;
	logic signed [NW-1:0] div_num;
	logic signed [31:0] div_quot;
	logic small_pivot, small_diag, op_matrix;

	lufs_ram #(.DEPTH(MAX_N * MAX_N), .WIDTH(32), .ADDR_W(AD)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	lufs_div #(.NW(NW), .FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(piv_q),
		.done(div_done), .quot(div_quot)
	);

	always_comb begin
		n_w = CW'(n_cfg_q);
		cfg_bad = (n_cfg_q == 4'd0) || (32'(n_cfg_q) > 32'(MAX_N)) || (tol_q == 31'd0);
		tol33 = 33'(tol_q);
		item_ready = (state_q == S_IDLE);
		cfg_ready = 1'b1;
		item_fire = item_valid && item_ready;
		cfg_fire = cfg_valid && cfg_ready;
		op_matrix = (item.operation == OP_MATRIX);
		out_free = !result_valid_q || result_ready;
		i_inc = i_q + CW'(1);
		j_inc = j_q + CW'(1);
		k_inc = k_q + CW'(1);
		e_inc = e_q + CW'(1);
		i_last = (i_inc == n_w);
		j_last = (j_inc == n_w);
		k_last = (k_inc == n_w);
		e_last = (e_inc == n_w);
		ld_r_last = (ld_r_q + CW'(1) == n_w);
		ld_c_last = (ld_c_q + CW'(1) == n_w);
		rcnt_last = (rcnt_q + CW'(1) == n_w);
		rdata = $signed(ram_rdata);
		fxp = sat32(prod_s1 >>> FRAC_BITS);
		elim_val = sat32(64'(33'(rdata) - 33'(fxp)));
		perm_rd = perm_q[perm_ra[IW-1:0]];
		work_rd = work_q[work_ra[IW-1:0]];
		fw_val = sat32(64'(NW'(rhs_q[perm_rd]) - NW'(acc_q)));
		mul_a = (state_q == S_EU_RB) ? m_q : work_rd;
		small_pivot = (bm_q <= tol33);
		small_diag = (mag33(rdata) <= tol33);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_fire) begin
					priority if (cfg_bad) begin
						state_d = S_STAT;
					end else if (op_matrix) begin
						if (ld_r_last && ld_c_last) state_d = S_PV_RD;
					end else if (!fok_q) begin
						state_d = S_STAT;
					end else if (rcnt_last) begin
						state_d = S_FW_START;
					end
				end
			end
			S_STAT:     if (out_free) state_d = S_IDLE;
			S_PV_RD:    state_d = S_PV_CMP;
			S_PV_CMP:   state_d = i_last ? S_PV_DONE : S_PV_RD;
			S_PV_DONE: begin
				priority if (small_pivot) state_d = S_STAT;
				else if (best_q != k_q) state_d = S_SW_RA;
				else state_d = S_NEXTI;
			end
			S_SW_RA:    state_d = S_SW_RB;
			S_SW_RB:    state_d = S_SW_WA;
			S_SW_WA:    state_d = S_SW_WB;
			S_SW_WB:    state_d = j_last ? S_PERM_A : S_SW_RA;
			S_PERM_A:   state_d = S_PERM_B;
			S_PERM_B:   state_d = S_PERM_C;
			S_PERM_C:   state_d = S_NEXTI;
			S_NEXTI:    state_d = i_last ? S_NEXTK : S_EL_RD;
			S_NEXTK:    state_d = k_last ? S_STAT : S_PV_RD;
			S_EL_RD:    state_d = S_EL_DIV;
			S_EL_DIV:   state_d = S_EL_DWAIT;
			S_EL_DWAIT: if (div_done) state_d = S_EU_RA;
			S_EU_RA:    state_d = S_EU_RB;
			S_EU_RB:    state_d = S_EU_WR;
			S_EU_WR:    state_d = j_last ? S_NEXTI : S_EU_RA;
			S_FW_START: state_d = (i_q == '0) ? S_FW_WR : S_FW_RD;
			S_FW_RD:    state_d = S_FW_MUL;
			S_FW_MUL:   state_d = S_FW_ACC;
			S_FW_ACC:   state_d = (j_inc == i_q) ? S_FW_WR : S_FW_RD;
			S_FW_WR:    state_d = i_last ? S_BK_RD : S_FW_START;
			S_BK_RD:    state_d = S_BK_CHK;
			S_BK_CHK: begin
				priority if (small_diag) state_d = S_STAT;
				else if (i_last) state_d = S_BK_DIV;
				else state_d = S_BK_RA;
			end
			S_BK_RA:    state_d = S_BK_MUL;
			S_BK_MUL:   state_d = S_BK_ACC;
			S_BK_ACC:   state_d = j_last ? S_BK_DIV : S_BK_RA;
			S_BK_DIV:   state_d = S_BK_DWAIT;
			S_BK_DWAIT: if (div_done) state_d = (i_q == '0) ? S_EMIT : S_BK_RD;
			S_EMIT:     if (out_free && e_last) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// memory ports, divider start and read selects
	always_comb begin
		rd_r = '0;
		rd_c = '0;
		wr_r = '0;
		wr_c = '0;
		ram_we = 1'b0;
		ram_wdata = '0;
		perm_ra = k_q;
		work_ra = j_q;
		div_start = 1'b0;
		div_num = NW'(rdata);
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				wr_r = ld_r_q;
				wr_c = ld_c_q;
				ram_we = item_fire && !cfg_bad && op_matrix;
				ram_wdata = item.value;
			end
			S_PV_RD: begin rd_r = i_q; rd_c = k_q; end
			S_SW_RA: begin rd_r = k_q; rd_c = j_q; end
			S_SW_RB: begin rd_r = best_q; rd_c = j_q; end
			S_SW_WA: begin
				wr_r = k_q; wr_c = j_q; ram_we = 1'b1; ram_wdata = ram_rdata;
			end
			S_SW_WB: begin
				wr_r = best_q; wr_c = j_q; ram_we = 1'b1; ram_wdata = a_q;
			end
			S_PERM_A: perm_ra = k_q;
			S_PERM_B: perm_ra = best_q;
			S_EL_RD: begin rd_r = i_q; rd_c = k_q; end
			S_EL_DIV: begin div_start = 1'b1; div_num = NW'(rdata); end
			S_EL_DWAIT: begin
				wr_r = i_q; wr_c = k_q; ram_we = div_done; ram_wdata = div_quot;
			end
			S_EU_RA: begin rd_r = k_q; rd_c = j_q; end
			S_EU_RB: begin rd_r = i_q; rd_c = j_q; end
			S_EU_WR: begin
				wr_r = i_q; wr_c = j_q; ram_we = 1'b1; ram_wdata = elim_val;
			end
			S_FW_RD: begin rd_r = i_q; rd_c = j_q; end
			S_FW_MUL: work_ra = j_q;
			S_FW_WR: perm_ra = i_q;
			S_BK_RD: begin rd_r = i_q; rd_c = i_q; end
			S_BK_RA: begin rd_r = i_q; rd_c = j_q; end
			S_BK_MUL: work_ra = j_q;
			S_BK_DIV: begin
				work_ra = i_q;
				div_start = 1'b1;
				div_num = NW'(work_rd) - NW'(acc_q);
			end
			S_STAT: out_load = out_free;
			S_EMIT: begin work_ra = e_q; out_load = out_free; end
			default: ;
		endcase
		ram_raddr = addr(rd_r, rd_c);
		ram_waddr = addr(wr_r, wr_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_cfg_q <= 4'd8;
			tol_q <= 31'd1;
			fok_q <= 1'b0;
			ld_r_q <= '0;
			ld_c_q <= '0;
			rcnt_q <= '0;
			result_valid_q <= 1'b0;
			for (int p = 0; p < MAX_N; p++) perm_q[p] <= IW'(p);
		end else begin
			state_q <= state_d;
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_fire) begin
						priority if (cfg_bad) begin
							ld_r_q <= '0;
							ld_c_q <= '0;
							rcnt_q <= '0;
							fok_q <= 1'b0;
						end else if (op_matrix) begin
							if (ld_r_q == '0 && ld_c_q == '0) begin
								fok_q <= 1'b0;
								rcnt_q <= '0;
							end
							if (ld_c_last) begin
								ld_c_q <= '0;
								ld_r_q <= ld_r_last ? '0 : ld_r_q + CW'(1);
								if (ld_r_last) begin
									for (int p = 0; p < MAX_N; p++) perm_q[p] <= IW'(p);
								end
							end else begin
								ld_c_q <= ld_c_q + CW'(1);
							end
						end else if (!fok_q) begin
							rcnt_q <= '0;
						end else begin
							rcnt_q <= rcnt_last ? '0 : rcnt_q + CW'(1);
						end
					end
				end
				S_PV_DONE: if (small_pivot) fok_q <= 1'b0;
				S_PERM_B: perm_q[k_q[IW-1:0]] <= perm_rd;
				S_PERM_C: perm_q[best_q[IW-1:0]] <= tmp_q;
				S_NEXTK: if (k_last) fok_q <= 1'b1;
				default: ;
			endcase
			if (cfg_fire) begin
				if (cfg_index == CFG_MATRIX_SIZE) begin
					n_cfg_q <= cfg_data[3:0];
					ld_r_q <= '0;
					ld_c_q <= '0;
					rcnt_q <= '0;
					fok_q <= 1'b0;
				end else if (cfg_index == CFG_PIVOT_TOL) begin
					tol_q <= cfg_data[30:0];
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_s1 <= 64'(mul_a) * 64'(rdata);
		unique case (state_q)
			S_IDLE: begin
				k_q <= '0;
				i_q <= '0;
				if (item_fire) begin
					priority if (cfg_bad) begin
						stat_kind_q <= item.operation;
						stat_code_q <= STAT_BAD_CFG;
					end else if (op_matrix) begin
						stat_kind_q <= KIND_FACTOR;
					end else if (!fok_q) begin
						stat_kind_q <= KIND_SOLVE;
						stat_code_q <= STAT_UNFACTORED;
					end else begin
						rhs_q[rcnt_q[IW-1:0]] <= item.value;
					end
				end
			end
			S_PV_CMP: begin
				if (i_q == k_q || mag33(rdata) > bm_q) begin
					bm_q <= mag33(rdata);
					best_q <= i_q;
					piv_q <= rdata;
				end
				if (!i_last) i_q <= i_inc;
			end
			S_PV_DONE: begin
				i_q <= k_q;
				j_q <= '0;
				stat_code_q <= STAT_SINGULAR;
			end
			S_SW_RB: a_q <= rdata;
			S_SW_WB: j_q <= j_inc;
			S_PERM_A: tmp_q <= perm_rd;
			S_PERM_C: i_q <= k_q;
			S_NEXTI: if (!i_last) i_q <= i_inc;
			S_NEXTK: begin
				stat_code_q <= STAT_OK;
				k_q <= k_inc;
				i_q <= k_inc;
			end
			S_EL_DWAIT: begin
				m_q <= div_quot;
				j_q <= k_inc;
			end
			S_EU_WR: j_q <= j_inc;
			S_FW_START: begin
				acc_q <= '0;
				j_q <= '0;
			end
			S_FW_ACC: begin
				acc_q <= acc_q + AW'(fxp);
				j_q <= j_inc;
			end
			S_FW_WR: begin
				work_q[i_q[IW-1:0]] <= fw_val;
				if (!i_last) i_q <= i_inc;
			end
			S_BK_CHK: begin
				piv_q <= rdata;
				acc_q <= '0;
				j_q <= i_inc;
				stat_kind_q <= KIND_SOLVE;
				stat_code_q <= STAT_SMALL_DIAG;
			end
			S_BK_ACC: begin
				acc_q <= acc_q + AW'(fxp);
				j_q <= j_inc;
			end
			S_BK_DWAIT: begin
				e_q <= '0;
				if (div_done) begin
					work_q[i_q[IW-1:0]] <= div_quot;
					if (i_q != '0) i_q <= i_q - CW'(1);
				end
			end
			S_STAT: begin
				if (out_load) begin
					result_q.kind <= stat_kind_q;
					result_q.status <= stat_code_q;
					result_q.element_index <= 3'd0;
					result_q.solution_value <= 32'sd0;
					result_q.last <= 1'b1;
				end
			end
			S_EMIT: begin
				if (out_load) begin
					result_q.kind <= KIND_SOLVE;
					result_q.status <= STAT_OK;
					result_q.element_index <= 3'(e_q);
					result_q.solution_value <= work_rd;
					result_q.last <= e_last;
					e_q <= e_inc;
				end
			end
			default: ;
		endcase
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	`LUFS_ASSERT_IMP(a_div_done_waited, clk, arst_n, div_done |-> (state_q == S_EL_DWAIT || state_q == S_BK_DWAIT), "divider finished outside a wait state")
	`LUFS_ASSERT_IMP(a_div_start_single, clk, arst_n, div_start |=> !div_start, "divider started twice in a row")
	`LUFS_ASSERT_IMP(a_load_when_free, clk, arst_n, out_load |-> (!result_valid_q || result_ready), "result register overwritten before transaction")
	`LUFS_ASSERT_NEVER(a_emit_in_range, clk, arst_n, out_load && state_q == S_EMIT && e_q >= n_w, "solution index beyond matrix order")

endmodule
